/* hdl/easing_curve_unit_assert.svh */
// Assertion macros for the easing curve unit.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef EASING_CURVE_UNIT_ASSERT_SVH
`define EASING_CURVE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ECU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("easing curve unit: same-cycle check failed");

// Next-cycle implication.
`define ECU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("easing curve unit: next-cycle check failed");

`endif

/* hdl/ecu_pkg.sv */
package ecu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FX_W      = FRAC_BITS + 1;
  localparam int TAB_BITS  = 8;
  localparam int TAB_N     = 1 << TAB_BITS;
  localparam int ROOT_W    = 2 * FRAC_BITS + 2;
  localparam int ROOT_STEPS = FRAC_BITS + 1;

  localparam logic [FX_W-1:0] ONE_FX  = FX_W'(1) << FRAC_BITS;
  localparam logic [63:0] Q62_ONE     = 64'd1 << 62;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // Curve selector codes.
  localparam logic [2:0] CURVE_LINEAR  = 3'd0;
  localparam logic [2:0] CURVE_SINE    = 3'd1;
  localparam logic [2:0] CURVE_SINE_SQ = 3'd2;
  localparam logic [2:0] CURVE_SQUARE  = 3'd3;
  localparam logic [2:0] CURVE_ROOT    = 3'd4;

  typedef logic [FX_W-1:0] sine_tab_t [0:TAB_N];

  // Bundle that flows down the root cell chain.
  typedef struct packed {
    logic              vld;
    logic              root;
    logic              bad;
    logic [FX_W-1:0]   alt;
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] res;
  } ecu_cell_t;

  // (a*b) >> 62, used only while building the table.
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[125:62];
  endfunction

  // Sine samples over a quarter period, evaluated at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] step;
    logic [63:0] rest;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    step = HALF_PI_Q62 / TAB_N;
    rest = HALF_PI_Q62 % TAB_N;
    for (int n = 0; n <= TAB_N; n++) begin
      x  = step * 64'(n) + (rest * 64'(n)) / TAB_N;
      x2 = mul_q62(x, x);
      t  = Q62_ONE;
      for (int k = 16; k >= 2; k -= 2) begin
        t = Q62_ONE - mul_q62(x2, t) / 64'(k * (k + 1));
      end
      s = mul_q62(x, t);
      r = (s + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
      tab[n] = (r > 64'(ONE_FX)) ? ONE_FX : FX_W'(r);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* hdl/ecu_front.sv */
module ecu_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [2:0]                          op,
  input  logic [ecu_pkg::FX_W-1:0]            progress,
  output ecu_pkg::ecu_cell_t                  cell_out
);

  localparam int W = ecu_pkg::FX_W;
  localparam int F = ecu_pkg::FRAC_BITS;
  localparam int IW = W - ecu_pkg::TAB_BITS;
  localparam int FW = F - ecu_pkg::TAB_BITS;

  // Stage one: clamp and table lookup.
  logic [W-1:0]  pc;
  logic [IW-1:0] idx;
  logic [W-1:0]  lo_c, hi_c;
  always_comb begin
    pc  = (progress > ecu_pkg::ONE_FX) ? ecu_pkg::ONE_FX : progress;
    idx = pc[W-1:FW];
    if (idx >= IW'(ecu_pkg::TAB_N)) begin
      lo_c = ecu_pkg::SINE_TAB[ecu_pkg::TAB_N];
      hi_c = ecu_pkg::SINE_TAB[ecu_pkg::TAB_N];
    end else begin
      lo_c = ecu_pkg::SINE_TAB[idx];
      hi_c = ecu_pkg::SINE_TAB[IW'(idx + IW'(1))];
      if (hi_c < lo_c) begin
        hi_c = lo_c;
      end
    end
  end

  logic         v1_r, v2_r, v3_r;
  logic [2:0]   op1_r, op2_r, op3_r;
  logic [W-1:0] p1_r, p2_r, p3_r;
  logic [W-1:0] lo1_r, diff1_r;
  logic [F-1:0] f1_r;
  logic [W-1:0] s2_r, sq2_r, alt3_r;
  logic         bad3_r;

  // Stage two: interpolation and square.
  logic [W+F-1:0] iprod;
  logic [2*W-1:0] pprod;
  logic [W-1:0]   s_nxt, sq_nxt;
  always_comb begin
    iprod  = (W+F)'(diff1_r) * (W+F)'(f1_r) + (W+F)'(ecu_pkg::ONE_FX >> 1);
    pprod  = (2*W)'(p1_r) * (2*W)'(p1_r) + (2*W)'(ecu_pkg::ONE_FX >> 1);
    s_nxt  = lo1_r + W'(iprod >> F);
    sq_nxt = W'(pprod >> F);
  end

  // Stage three: sine squared and curve select.
  logic [2*W-1:0] ssprod;
  logic [W-1:0]   alt_nxt;
  logic           bad_nxt;
  always_comb begin
    ssprod  = (2*W)'(s2_r) * (2*W)'(s2_r) + (2*W)'(ecu_pkg::ONE_FX >> 1);
    bad_nxt = 1'b0;
    case (op2_r)
      ecu_pkg::CURVE_LINEAR:  alt_nxt = p2_r;
      ecu_pkg::CURVE_SINE:    alt_nxt = s2_r;
      ecu_pkg::CURVE_SINE_SQ: alt_nxt = W'(ssprod >> F);
      ecu_pkg::CURVE_SQUARE:  alt_nxt = sq2_r;
      ecu_pkg::CURVE_ROOT:    alt_nxt = '0;
      default: begin
        alt_nxt = '0;
        bad_nxt = 1'b1;
      end
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= op;
      p1_r    <= pc;
      lo1_r   <= lo_c;
      diff1_r <= hi_c - lo_c;
      f1_r    <= {pc[FW-1:0], ecu_pkg::TAB_BITS'(0)};
      op2_r   <= op1_r;
      p2_r    <= p1_r;
      s2_r    <= s_nxt;
      sq2_r   <= sq_nxt;
      op3_r   <= op2_r;
      p3_r    <= p2_r;
      alt3_r  <= alt_nxt;
      bad3_r  <= bad_nxt;
    end
  end

  // Root operand is p shifted up by the fraction width.
  always_comb begin
    cell_out.vld  = v3_r;
    cell_out.root = (op3_r == ecu_pkg::CURVE_ROOT);
    cell_out.bad  = bad3_r;
    cell_out.alt  = alt3_r;
    cell_out.rem  = ecu_pkg::ROOT_W'(p3_r) << F;
    cell_out.res  = '0;
  end

endmodule

/* hdl/ecu_root_cell.sv */
module ecu_root_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ecu_pkg::ecu_cell_t cell_in,
  output ecu_pkg::ecu_cell_t cell_out
);

  localparam int RW = ecu_pkg::ROOT_W;
  localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ecu_pkg::ROOT_STEPS - 1 - STEP));

  ecu_pkg::ecu_cell_t cell_r, cell_nxt;
  logic [RW-1:0]      trial;

  // One digit of the square root per cell.
  always_comb begin
    cell_nxt = cell_in;
    trial    = cell_in.res + BIT;
    if (cell_in.rem >= trial) begin
      cell_nxt.rem = cell_in.rem - trial;
      cell_nxt.res = (cell_in.res >> 1) + BIT;
    end else begin
      cell_nxt.res = cell_in.res >> 1;
    end
  end

  // Only the valid bit is reset; the payload follows the enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (en) begin
      cell_r.root <= cell_nxt.root;
      cell_r.bad  <= cell_nxt.bad;
      cell_r.alt  <= cell_nxt.alt;
      cell_r.rem  <= cell_nxt.rem;
      cell_r.res  <= cell_nxt.res;
    end
  end

  assign cell_out = cell_r;

endmodule

/* hdl/easing_curve_unit.sv */
// Pipeline: 3 front stages, 17 square root cells and 1 output register lie
// between an input transfer and its result.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a result waits at the output register.
// Reset: synchronous, active low; clears all valid bits, the table is constant.
module easing_curve_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] progress, [23:17] zero
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] eased, [23:17] zero
  output logic        out_tuser   // [0] bad_curve
);

  localparam int W  = ecu_pkg::FX_W;
  localparam int N  = ecu_pkg::ROOT_STEPS;
  localparam int RW = ecu_pkg::ROOT_W;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  ecu_pkg::ecu_cell_t chain [0:N];

  ecu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .op       (in_tuser),
    .progress (in_tdata[W-1:0]),
    .cell_out (chain[0])
  );

  // Row of square root cells.
  for (genvar g = 0; g < N; g++) begin : g_cell
    ecu_root_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  // Final rounding, select and clamp.
  logic [RW-1:0] root_val;
  logic [W-1:0]  eased_nxt;
  always_comb begin
    root_val = (chain[N].rem > chain[N].res) ? chain[N].res + RW'(1) : chain[N].res;
    if (chain[N].root) begin
      eased_nxt = (root_val > RW'(ecu_pkg::ONE_FX)) ? ecu_pkg::ONE_FX : W'(root_val);
    end else begin
      eased_nxt = chain[N].alt;
    end
  end

  logic         out_vld_r;
  logic [W-1:0] eased_r;
  logic         bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= chain[N].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eased_r <= eased_nxt;
      bad_r   <= chain[N].bad;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(24-W)'(0), eased_r};
  assign out_tuser  = bad_r;

`include "easing_curve_unit_assert.svh"

  `ECU_ASSERT_IMP(a_bad_zero, out_tvalid && out_tuser, out_tdata == 24'd0)
  `ECU_ASSERT_IMP(a_range, out_tvalid, out_tdata[W-1:0] <= ecu_pkg::ONE_FX)
  `ECU_ASSERT_IMP(a_stall_src, !in_tready, out_tvalid && !out_tready)

endmodule
